@@ hw/rtl/llqm_pkg.sv @@
package llqm_pkg;

	localparam int ACTION_W = 1;
	localparam int QUEUE_ID_W = 3;
	localparam int NODE_ID_W = 6;
	localparam int STATUS_W = 2;
	localparam int QUEUE_LENGTH_W = 7;
	localparam int HEAD_NODE_W = 6;

	localparam logic ACTION_APPEND = 1'b0;
	localparam logic ACTION_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_QUEUED  = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FOREIGN = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_TAIL,
		S_LINK,
		S_FIN
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic look;
		logic tail;
		logic link;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic grow;
		logic out_free;
	} stat_t;

endpackage

@@ hw/rtl/llqm_ifs.sv @@
interface llqm_req_if;
	logic valid;
	logic ready;
	logic action;
	logic [llqm_pkg::QUEUE_ID_W-1:0] queue_id;
	logic [llqm_pkg::NODE_ID_W-1:0] node_id;

	modport source(output valid, output action, output queue_id, output node_id, input ready);
	modport sink(input valid, input action, input queue_id, input node_id, output ready);
endinterface

interface llqm_rsp_if;
	logic valid;
	logic ready;
	logic [llqm_pkg::STATUS_W-1:0] status;
	logic [llqm_pkg::QUEUE_LENGTH_W-1:0] queue_length;
	logic [llqm_pkg::HEAD_NODE_W-1:0] head_node;
	logic queue_empty;

	modport source(output valid, output status, output queue_length, output head_node,
		output queue_empty, input ready);
	modport sink(input valid, input status, input queue_length, input head_node,
		input queue_empty, output ready);
endinterface

@@ hw/rtl/linked_list_queue_manager_top.sv @@
// Channel  Dir  Fields                                          Ready means
// req      in   action, queue_id, node_id                       block idle, word taken
// rsp      out  status, queue_length, head_node, queue_empty    downstream takes word
//
// A word passes through the block in an accept, a lookup and a finish step; an append that
// succeeds on a queue that is not empty adds a tail and a link step on the single-port link
// memories. The result register loads in the finish step, after the lookup or link step.
// After reset, a clearing pass over every node and queue entry holds req.ready low.
// A waiting result does not block acceptance; the next word holds in its finish step
// until the result register is free.
module linked_list_queue_manager_top #(
	parameter int NODE_COUNT  = 64,
	parameter int QUEUE_COUNT = 8
) (
	input logic       clk,
	input logic       arst_n,
	llqm_req_if.sink  req,
	llqm_rsp_if.source rsp
);

	llqm_pkg::cmd_t  cmd;
	llqm_pkg::stat_t stat;

	llqm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	llqm_dp #(
		.NODE_COUNT  (NODE_COUNT),
		.QUEUE_COUNT (QUEUE_COUNT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.in_action        (req.action),
		.in_queue_id      (req.queue_id),
		.in_node_id       (req.node_id),
		.out_ready        (rsp.ready),
		.out_valid        (rsp.valid),
		.out_status       (rsp.status),
		.out_queue_length (rsp.queue_length),
		.out_head_node    (rsp.head_node),
		.out_queue_empty  (rsp.queue_empty)
	);

`ifndef SYNTHESIS
	a_accept_then_look: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> cmd.look)
		else $error("accepted word not followed by lookup");

	a_finish_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> rsp.valid)
		else $error("finished word did not reach the result register");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.accept, cmd.look, cmd.tail, cmd.link, cmd.finish}))
		else $error("more than one controller step at once");

	a_tail_then_link: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tail |=> cmd.link)
		else $error("tail write not followed by link write");
`endif

endmodule

@@ hw/rtl/llqm_ctrl.sv @@
module llqm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  llqm_pkg::stat_t  stat,
	output llqm_pkg::cmd_t   cmd
);

	llqm_pkg::state_t state_q;
	llqm_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= llqm_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			llqm_pkg::S_CLEAR: begin
				if (stat.clear_done) begin
					state_d = llqm_pkg::S_IDLE;
				end
			end
			llqm_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = llqm_pkg::S_LOOK;
				end
			end
			llqm_pkg::S_LOOK: begin
				state_d = stat.grow ? llqm_pkg::S_TAIL : llqm_pkg::S_FIN;
			end
			llqm_pkg::S_TAIL: begin
				state_d = llqm_pkg::S_LINK;
			end
			llqm_pkg::S_LINK: begin
				state_d = llqm_pkg::S_FIN;
			end
			llqm_pkg::S_FIN: begin
				if (stat.out_free) begin
					state_d = llqm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = llqm_pkg::S_CLEAR;
			end
		endcase
	end

	always_comb begin
		in_ready   = (state_q == llqm_pkg::S_IDLE);
		cmd.clear  = (state_q == llqm_pkg::S_CLEAR);
		cmd.accept = (state_q == llqm_pkg::S_IDLE) && in_valid;
		cmd.look   = (state_q == llqm_pkg::S_LOOK);
		cmd.tail   = (state_q == llqm_pkg::S_TAIL);
		cmd.link   = (state_q == llqm_pkg::S_LINK);
		cmd.finish = (state_q == llqm_pkg::S_FIN) && stat.out_free;
	end

endmodule

@@ hw/rtl/llqm_dp.sv @@
module llqm_dp #(
	parameter int NODE_COUNT  = 64,
	parameter int QUEUE_COUNT = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  llqm_pkg::cmd_t                          cmd,
	output llqm_pkg::stat_t                         stat,
	input  logic                                    in_action,
	input  logic [llqm_pkg::QUEUE_ID_W-1:0]         in_queue_id,
	input  logic [llqm_pkg::NODE_ID_W-1:0]          in_node_id,
	input  logic                                    out_ready,
	output logic                                    out_valid,
	output logic [llqm_pkg::STATUS_W-1:0]           out_status,
	output logic [llqm_pkg::QUEUE_LENGTH_W-1:0]     out_queue_length,
	output logic [llqm_pkg::HEAD_NODE_W-1:0]        out_head_node,
	output logic                                    out_queue_empty
);

	localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int LW = $clog2(NODE_COUNT + 1);
	localparam int CLR_LEN = (NODE_COUNT > QUEUE_COUNT) ? NODE_COUNT : QUEUE_COUNT;
	localparam int CW = $clog2(CLR_LEN);

	logic                              act_q;
	logic [llqm_pkg::QUEUE_ID_W-1:0]   qid_q;
	logic [llqm_pkg::NODE_ID_W-1:0]    nid_q;

	logic          queued_mem [NODE_COUNT];
	logic [QW-1:0] owner_mem  [NODE_COUNT];
	logic [NW-1:0] next_mem   [NODE_COUNT];
	logic [NW-1:0] prev_mem   [NODE_COUNT];
	logic [LW-1:0] qlen_mem   [QUEUE_COUNT];
	logic [NW-1:0] qhead_mem  [QUEUE_COUNT];

	logic          queued_rd_q;
	logic [QW-1:0] owner_rd_q;
	logic [NW-1:0] next_rd_q;
	logic [NW-1:0] prev_rd_q;
	logic [LW-1:0] qlen_rd_q;
	logic [NW-1:0] qhead_rd_q;

	logic [CW-1:0] clr_cnt_q;
	logic [NW-1:0] head_q;

	llqm_pkg::status_t res_status_q;
	logic [LW-1:0]     res_len_q;
	logic [NW-1:0]     res_head_q;

	logic                                out_valid_q;
	llqm_pkg::status_t                   out_status_q;
	logic [llqm_pkg::QUEUE_LENGTH_W-1:0] out_len_q;
	logic [llqm_pkg::HEAD_NODE_W-1:0]    out_head_q;
	logic                                out_empty_q;

	logic [QW-1:0]     q_idx;
	logic [NW-1:0]     n_idx;
	logic              q_ok;
	logic              n_ok;
	logic              is_append;
	logic              was_empty;
	llqm_pkg::status_t status_c;
	logic              commit;
	logic [LW-1:0]     len_new;
	logic [NW-1:0]     head_new;

	logic [NW-1:0] nd_addr;
	logic          nd_we;
	logic          nd_queued_wd;
	logic          nd_owner_we;
	logic [NW-1:0] nx_addr;
	logic          nx_we;
	logic [NW-1:0] nx_wd;
	logic [NW-1:0] pv_addr;
	logic          pv_we;
	logic [NW-1:0] pv_wd;
	logic [QW-1:0] qu_addr;
	logic          qu_we;
	logic          qu_head_we;

	assign q_idx     = QW'(qid_q);
	assign n_idx     = NW'(nid_q);
	assign q_ok      = int'(qid_q) < QUEUE_COUNT;
	assign n_ok      = int'(nid_q) < NODE_COUNT;
	assign is_append = (act_q == llqm_pkg::ACTION_APPEND);
	assign was_empty = (qlen_rd_q == '0);

	always_comb begin
		if (!q_ok) begin
			status_c = llqm_pkg::ST_EMPTY;
		end else if (is_append) begin
			status_c = (!n_ok || queued_rd_q) ? llqm_pkg::ST_QUEUED : llqm_pkg::ST_OK;
		end else if (was_empty) begin
			status_c = llqm_pkg::ST_EMPTY;
		end else if (!n_ok || !queued_rd_q || owner_rd_q != q_idx) begin
			status_c = llqm_pkg::ST_FOREIGN;
		end else begin
			status_c = llqm_pkg::ST_OK;
		end
	end

	assign commit = (status_c == llqm_pkg::ST_OK);

	always_comb begin
		len_new  = qlen_rd_q;
		head_new = qhead_rd_q;
		if (commit && is_append) begin
			len_new = qlen_rd_q + LW'(1);
			if (was_empty) begin
				head_new = n_idx;
			end
		end else if (commit) begin
			len_new = qlen_rd_q - LW'(1);
			if (qhead_rd_q == n_idx) begin
				head_new = next_rd_q;
			end
		end
	end

	always_comb begin
		nd_addr      = n_idx;
		nd_we        = 1'b0;
		nd_queued_wd = 1'b0;
		nd_owner_we  = 1'b0;
		nx_addr      = n_idx;
		nx_we        = 1'b0;
		nx_wd        = n_idx;
		pv_addr      = n_idx;
		pv_we        = 1'b0;
		pv_wd        = n_idx;
		qu_addr      = q_idx;
		qu_we        = 1'b0;
		qu_head_we   = 1'b0;
		if (cmd.clear) begin
			nd_addr = NW'(clr_cnt_q);
			nd_we   = int'(clr_cnt_q) < NODE_COUNT;
			qu_addr = QW'(clr_cnt_q);
			qu_we   = int'(clr_cnt_q) < QUEUE_COUNT;
		end else if (cmd.accept) begin
			nd_addr = NW'(in_node_id);
			nx_addr = NW'(in_node_id);
			pv_addr = NW'(in_node_id);
			qu_addr = QW'(in_queue_id);
		end else if (cmd.look) begin
			nd_we        = commit;
			nd_queued_wd = is_append;
			nd_owner_we  = commit && is_append;
			qu_we        = commit;
			qu_head_we   = commit;
			nx_we        = commit;
			if (is_append) begin
				nx_wd   = was_empty ? n_idx : qhead_rd_q;
				pv_addr = was_empty ? n_idx : qhead_rd_q;
				pv_we   = commit && was_empty;
			end else begin
				nx_addr = prev_rd_q;
				nx_wd   = next_rd_q;
				pv_addr = next_rd_q;
				pv_wd   = prev_rd_q;
				pv_we   = commit;
			end
		end else if (cmd.tail) begin
			nx_addr = prev_rd_q;
			nx_wd   = n_idx;
			nx_we   = 1'b1;
			pv_wd   = prev_rd_q;
			pv_we   = 1'b1;
		end else if (cmd.link) begin
			pv_addr = head_q;
			pv_wd   = n_idx;
			pv_we   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (nd_we) begin
			queued_mem[nd_addr] <= nd_queued_wd;
		end
		if (nd_owner_we) begin
			owner_mem[nd_addr] <= q_idx;
		end
		queued_rd_q <= queued_mem[nd_addr];
		owner_rd_q  <= owner_mem[nd_addr];
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_addr] <= nx_wd;
		end
		next_rd_q <= next_mem[nx_addr];
	end

	always_ff @(posedge clk) begin
		if (pv_we) begin
			prev_mem[pv_addr] <= pv_wd;
		end
		prev_rd_q <= prev_mem[pv_addr];
	end

	always_ff @(posedge clk) begin
		if (qu_we) begin
			qlen_mem[qu_addr] <= cmd.clear ? '0 : len_new;
		end
		if (qu_head_we) begin
			qhead_mem[qu_addr] <= head_new;
		end
		qlen_rd_q  <= qlen_mem[qu_addr];
		qhead_rd_q <= qhead_mem[qu_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear && !stat.clear_done) begin
			clr_cnt_q <= clr_cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q <= in_action;
			qid_q <= in_queue_id;
			nid_q <= in_node_id;
		end
		if (cmd.look) begin
			head_q       <= qhead_rd_q;
			res_status_q <= status_c;
			res_len_q    <= q_ok ? len_new : '0;
			res_head_q   <= (q_ok && len_new != '0) ? head_new : '0;
		end
		if (cmd.finish) begin
			out_status_q <= res_status_q;
			out_len_q    <= llqm_pkg::QUEUE_LENGTH_W'(res_len_q);
			out_head_q   <= llqm_pkg::HEAD_NODE_W'(res_head_q);
			out_empty_q  <= (res_len_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.clear_done = (clr_cnt_q == CW'(CLR_LEN - 1));
	assign stat.grow       = commit && is_append && !was_empty;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid        = out_valid_q;
	assign out_status       = out_status_q;
	assign out_queue_length = out_len_q;
	assign out_head_node    = out_head_q;
	assign out_queue_empty  = out_empty_q;

endmodule

@@ test/linked_list_queue_manager_top_test.sv @@
module linked_list_queue_manager_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODE_COUNT = 64;
	localparam int QUEUE_COUNT = 8;
	localparam int CLOCK_HALF = 5;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;
	localparam int REPORT_LIMIT = 10;

	typedef logic [llqm_pkg::QUEUE_ID_W-1:0] queue_id_t;
	typedef logic [llqm_pkg::NODE_ID_W-1:0] node_id_t;

	typedef struct {
		llqm_pkg::status_t status;
		logic [llqm_pkg::QUEUE_LENGTH_W-1:0] length;
		logic [llqm_pkg::HEAD_NODE_W-1:0] head;
		logic empty;
	} outcome_t;

	logic clk;
	logic arst_n;

	llqm_req_if req_if ();
	llqm_rsp_if rsp_if ();

	linked_list_queue_manager_top #(
		.NODE_COUNT(NODE_COUNT),
		.QUEUE_COUNT(QUEUE_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	node_id_t node_next [NODE_COUNT];
	node_id_t node_prev [NODE_COUNT];
	logic node_busy [NODE_COUNT];
	queue_id_t node_queue [NODE_COUNT];
	node_id_t queue_head [QUEUE_COUNT];
	int queue_len [QUEUE_COUNT];

	outcome_t pending_outcomes [$];
	int mismatch_count = 0;
	bit no_gaps = 1'b0;
	bit hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #CLOCK_HALF clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("linked_list_queue_manager_top: mismatch");
		$finish;
	end

	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_gaps || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic outcome_t predict_queue_op(logic act, queue_id_t q, node_id_t n);
		outcome_t res;
		node_id_t h;
		node_id_t t;
		node_id_t nx;
		node_id_t pv;
		if (act == llqm_pkg::ACTION_APPEND) begin
			if (node_busy[n]) begin
				res.status = llqm_pkg::ST_QUEUED;
			end else begin
				if (queue_len[q] == 0) begin
					queue_head[q] = n;
					node_next[n] = n;
					node_prev[n] = n;
				end else begin
					h = queue_head[q];
					t = node_prev[h];
					node_next[n] = h;
					node_prev[n] = t;
					node_next[t] = n;
					node_prev[h] = n;
				end
				node_busy[n] = 1'b1;
				node_queue[n] = q;
				queue_len[q]++;
				res.status = llqm_pkg::ST_OK;
			end
		end else begin
			if (queue_len[q] == 0) begin
				res.status = llqm_pkg::ST_EMPTY;
			end else if (!node_busy[n] || node_queue[n] != q) begin
				res.status = llqm_pkg::ST_FOREIGN;
			end else begin
				nx = node_next[n];
				pv = node_prev[n];
				if (queue_head[q] == n)
					queue_head[q] = nx;
				node_prev[nx] = pv;
				node_next[pv] = nx;
				node_busy[n] = 1'b0;
				queue_len[q]--;
				res.status = llqm_pkg::ST_OK;
			end
		end
		res.length = queue_len[q][llqm_pkg::QUEUE_LENGTH_W-1:0];
		res.head = (queue_len[q] != 0) ? queue_head[q] : '0;
		res.empty = (queue_len[q] == 0);
		return res;
	endfunction

	task automatic note_mismatch(string what, outcome_t want, outcome_t got);
		string want_text;
		string got_text;
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			want_text = $sformatf("status %0d length %0d head %0d empty %0d",
				want.status, want.length, want.head, want.empty);
			got_text = $sformatf("status %0d length %0d head %0d empty %0d",
				got.status, got.length, got.head, got.empty);
			$display("%s: expected %s, got %s", what, want_text, got_text);
		end
	endtask

	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got.status = llqm_pkg::status_t'(rsp_if.status);
			got.length = rsp_if.queue_length;
			got.head = rsp_if.head_node;
			got.empty = rsp_if.queue_empty;
			if (pending_outcomes.size() == 0) begin
				want = '{llqm_pkg::ST_OK, '0, '0, 1'b0};
				note_mismatch("unexpected word", want, got);
			end else begin
				want = pending_outcomes.pop_front();
				if (got.status !== want.status || got.length !== want.length ||
					got.head !== want.head || got.empty !== want.empty)
					note_mismatch("result word", want, got);
			end
		end
	end

	initial begin
		int stall_left;
		int gap;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				rsp_if.ready <= 1'b1;
			end else if (stall_left > 0) begin
				rsp_if.ready <= 1'b0;
				stall_left--;
			end else begin
				gap = idle_length();
				if (gap == 0) begin
					rsp_if.ready <= 1'b1;
				end else begin
					rsp_if.ready <= 1'b0;
					stall_left = gap - 1;
				end
			end
		end
	end

	// Called and returns at a falling edge; valid is left high when no gap follows.
	task automatic send_word(logic act, queue_id_t q, node_id_t n);
		int gap;
		req_if.valid <= 1'b1;
		req_if.action <= act;
		req_if.queue_id <= q;
		req_if.node_id <= n;
		do
			@(posedge clk);
		while (!req_if.ready);
		pending_outcomes.push_back(predict_queue_op(act, q, n));
		@(negedge clk);
		gap = idle_length();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic random_word(int append_pct, int queue_span);
		node_id_t idle_nodes [$];
		node_id_t own_nodes [$];
		logic act;
		queue_id_t q;
		node_id_t n;
		bit want_append;
		q = queue_id_t'($urandom_range(0, queue_span));
		n = node_id_t'($urandom_range(0, NODE_COUNT - 1));
		if ($urandom_range(0, 99) < 10) begin
			act = 1'($urandom_range(0, 1));
			q = queue_id_t'($urandom_range(0, QUEUE_COUNT - 1));
		end else begin
			for (int i = 0; i < NODE_COUNT; i++) begin
				if (!node_busy[i])
					idle_nodes.push_back(node_id_t'(i));
				else if (node_queue[i] == q)
					own_nodes.push_back(node_id_t'(i));
			end
			want_append = ($urandom_range(0, 99) < append_pct);
			if (want_append && idle_nodes.size() > 0) begin
				act = llqm_pkg::ACTION_APPEND;
				n = idle_nodes[$urandom_range(0, idle_nodes.size() - 1)];
			end else if (!want_append && own_nodes.size() > 0) begin
				act = llqm_pkg::ACTION_REMOVE;
				n = own_nodes[$urandom_range(0, own_nodes.size() - 1)];
			end else begin
				act = want_append ? llqm_pkg::ACTION_APPEND : llqm_pkg::ACTION_REMOVE;
			end
		end
		send_word(act, q, n);
	endtask

	task automatic drain_all_queues();
		for (int i = 0; i < NODE_COUNT; i++)
			if (node_busy[i])
				send_word(llqm_pkg::ACTION_REMOVE, node_queue[i], node_id_t'(i));
	endtask

	task automatic test_directed_cases();
		send_word(llqm_pkg::ACTION_REMOVE, 3'd0, 6'd0);
		send_word(llqm_pkg::ACTION_APPEND, 3'd0, 6'd0);
		send_word(llqm_pkg::ACTION_APPEND, 3'd0, 6'd63);
		send_word(llqm_pkg::ACTION_APPEND, 3'd7, 6'd63);
		send_word(llqm_pkg::ACTION_APPEND, 3'd0, 6'd0);
		send_word(llqm_pkg::ACTION_REMOVE, 3'd7, 6'd0);
		send_word(llqm_pkg::ACTION_APPEND, 3'd7, 6'd5);
		send_word(llqm_pkg::ACTION_REMOVE, 3'd7, 6'd0);
		send_word(llqm_pkg::ACTION_REMOVE, 3'd7, 6'd6);
		send_word(llqm_pkg::ACTION_REMOVE, 3'd0, 6'd0);
		send_word(llqm_pkg::ACTION_REMOVE, 3'd0, 6'd63);
		send_word(llqm_pkg::ACTION_REMOVE, 3'd0, 6'd63);
		send_word(llqm_pkg::ACTION_APPEND, 3'd0, 6'd63);
		send_word(llqm_pkg::ACTION_APPEND, 3'd3, 6'd10);
		send_word(llqm_pkg::ACTION_APPEND, 3'd3, 6'd20);
		send_word(llqm_pkg::ACTION_APPEND, 3'd3, 6'd30);
		send_word(llqm_pkg::ACTION_REMOVE, 3'd3, 6'd20);
		send_word(llqm_pkg::ACTION_REMOVE, 3'd3, 6'd30);
		send_word(llqm_pkg::ACTION_REMOVE, 3'd3, 6'd10);
		send_word(llqm_pkg::ACTION_REMOVE, 3'd7, 6'd5);
		send_word(llqm_pkg::ACTION_REMOVE, 3'd0, 6'd63);
	endtask

	task automatic test_full_pool();
		node_id_t order [NODE_COUNT];
		node_id_t swap;
		queue_id_t q;
		int j;
		drain_all_queues();
		q = queue_id_t'($urandom_range(0, QUEUE_COUNT - 1));
		for (int i = 0; i < NODE_COUNT; i++)
			order[i] = node_id_t'(i);
		for (int i = NODE_COUNT - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		for (int i = 0; i < NODE_COUNT; i++)
			send_word(llqm_pkg::ACTION_APPEND, q, order[i]);
		send_word(llqm_pkg::ACTION_APPEND, q + 3'd1, order[0]);
		for (int i = NODE_COUNT - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		for (int i = 0; i < NODE_COUNT; i++)
			send_word(llqm_pkg::ACTION_REMOVE, q, order[i]);
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		for (int i = 0; i < 150; i++)
			random_word(55, $urandom_range(0, QUEUE_COUNT - 1));
		no_gaps = 1'b0;
	endtask

	task automatic test_output_backpressure();
		hold_request = 1'b1;
		no_gaps = 1'b1;
		for (int i = 0; i < 30; i++)
			random_word(60, 1);
		no_gaps = 1'b0;
	endtask

	task automatic test_random_traffic();
		int spans [4] = '{0, 1, 3, 7};
		for (int chunk = 0; chunk < 16; chunk++)
			for (int i = 0; i < 100; i++)
				random_word((chunk % 2 == 0) ? 70 : 30, spans[$urandom_range(0, 3)]);
	endtask

	initial begin
		for (int i = 0; i < NODE_COUNT; i++) begin
			node_next[i] = '0;
			node_prev[i] = '0;
			node_busy[i] = 1'b0;
			node_queue[i] = '0;
		end
		for (int i = 0; i < QUEUE_COUNT; i++) begin
			queue_head[i] = '0;
			queue_len[i] = 0;
		end
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.action = llqm_pkg::ACTION_APPEND;
		req_if.queue_id = '0;
		req_if.node_id = '0;
		rsp_if.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_full_pool();
		test_back_to_back();
		test_output_backpressure();
		test_random_traffic();
		test_full_pool();

		req_if.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("linked_list_queue_manager_top: match");
		else
			$display("linked_list_queue_manager_top: mismatch");
		$finish;
	end

endmodule
